/* design/assert_macros.svh */
// assertion macros shared by the rtl of the clustering core
// no dependencies; synthesis builds define SYNTH to drop the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MLCM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define MLCM_ASSERT_NEVER(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error("check failed");
`else
`define MLCM_ASSERT(name, clk, rst, prop)
`define MLCM_ASSERT_NEVER(name, clk, rst, prop)
`endif
`endif

/* design/mlcm_pkg.sv */
// constants and codes of the median linkage clustering core
// no dependencies
package mlcm_pkg;
   localparam int IdW        = 7;
   localparam int GroupW     = 6;
   localparam int RankW      = 8;
   localparam int LinkW      = 16;
   localparam int NumGroupsW = 7;
   localparam int DimW       = 9;
   localparam int CsrDataW   = 9;
   localparam int LinkDepth  = 1 << (2 * IdW);

   localparam logic [LinkW-1:0]      LinkSat        = 16'hFFFF;
   localparam logic [IdW-1:0]        NoCluster      = 7'h7F;
   localparam logic [NumGroupsW-1:0] NumGroupsReset = 7'd2;
   localparam logic [DimW-1:0]       DimReset       = 9'd136;

   localparam logic KindLoad     = 1'b0;
   localparam logic KindRun      = 1'b1;
   localparam logic CsrNumGroups = 1'b0;
   localparam logic CsrDimInUse  = 1'b1;
endpackage

/* design/median_linkage_cluster_merge_core.sv */
// top level of the median linkage clustering core: sequencer, distance unit, stores
// depends on mlcm_pkg, mlcm_ram and assert_macros.svh
//
// usage
//   req channel (valid/stall): kind 0 loads one rank element of the current vector
//   (tagged with its group, vector_end closes the vector); kind 1 starts a run.
//   a run gives num_groups-1 rsp transactions (num_groups clamped to 2..MAX_GROUPS),
//   one per merge, rsp_last on the final one; req_stall stays high for the whole run.
//   csr port: index 0 num_groups, index 1 dim_in_use, written while idle.
//   during a run, each linkage scans the labels of the V loaded vectors, then makes
//   16 search passes over all na*nb member pairs, as one shared distance unit
//   reads both vectors through the single rank store read port. picking the best
//   pair walks the link table, skipping retired slots, and each merge relabels the
//   members of both children in the label store.
//   when the receiver stalls, the merge result holds and the sequencer waits.
//   reset clears the load counters, the overflow flag and the retired flags; the
//   stores need no clearing pass.
//
module median_linkage_cluster_merge_core
   import mlcm_pkg::*;
#(
   parameter int MAX_GROUPS  = 64,
   parameter int MAX_VECTORS = 1024,
   parameter int MAX_DIM     = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [GroupW-1:0]     req_group,
   input  logic [RankW-1:0]      req_rank_value,
   input  logic                  req_vector_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IdW-1:0]        rsp_child_first,
   output logic [IdW-1:0]        rsp_child_second,
   output logic [IdW-1:0]        rsp_new_cluster,
   output logic [LinkW-1:0]      rsp_linkage,
   output logic                  rsp_last,
   output logic                  rsp_store_overflow,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [CsrDataW-1:0]   csr_data
);
`include "assert_macros.svh"

   localparam int VIW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int VCW = $clog2(MAX_VECTORS + 1);
   localparam int DIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int RankDepth = MAX_VECTORS * MAX_DIM;
   localparam int RAW = $clog2(RankDepth);
   localparam int CW  = 2 * VCW;
   localparam int NumIds = 1 << IdW;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CP_RD   = 5'd1;
   localparam logic [4:0] S_CP_WR   = 5'd2;
   localparam logic [4:0] S_LS_RD   = 5'd3;
   localparam logic [4:0] S_LS_CHK  = 5'd4;
   localparam logic [4:0] S_LS_END  = 5'd5;
   localparam logic [4:0] S_P_ADDR  = 5'd6;
   localparam logic [4:0] S_P_BASE  = 5'd7;
   localparam logic [4:0] S_E_RDA   = 5'd8;
   localparam logic [4:0] S_E_RDB   = 5'd9;
   localparam logic [4:0] S_E_ACC   = 5'd10;
   localparam logic [4:0] S_P_CMP   = 5'd11;
   localparam logic [4:0] S_B_END   = 5'd12;
   localparam logic [4:0] S_LK_DONE = 5'd13;
   localparam logic [4:0] S_FB_NEXT = 5'd14;
   localparam logic [4:0] S_FB_CMP  = 5'd15;
   localparam logic [4:0] S_EMIT    = 5'd16;
   localparam logic [4:0] S_RL_RD   = 5'd17;
   localparam logic [4:0] S_RL_WR   = 5'd18;
   localparam logic [4:0] S_NL_NEXT = 5'd19;

   typedef struct packed {
      logic [4:0]        state;
      logic [IdW-1:0]    ng;
      logic [DIW-1:0]    dim_m1;
      logic [IdW-1:0]    next;
      logic [IdW:0]      li;
      logic [IdW:0]      lj;
      logic              phase;
      logic [VCW-1:0]    v;
      logic [VCW-1:0]    na;
      logic [VCW-1:0]    nb;
      logic [VCW-1:0]    pi;
      logic [VCW-1:0]    pj;
      logic [IdW-1:0]    ca;
      logic [IdW-1:0]    cb;
      logic [RAW-1:0]    base_a;
      logic [RAW-1:0]    base_b;
      logic [DIW-1:0]    e;
      logic [RankW-1:0]  ra;
      logic [LinkW-1:0]  acc;
      logic [CW-1:0]     k;
      logic [CW-1:0]     cnt;
      logic [3:0]        bitpos;
      logic [LinkW-1:0]  m;
      logic [LinkW-1:0]  t;
      logic [LinkW-1:0]  lres;
      logic [IdW:0]      si;
      logic [IdW:0]      sj;
      logic              found;
      logic [LinkW-1:0]  best;
      logic [IdW-1:0]    c1;
      logic [IdW-1:0]    c2;
      logic [NumIds-1:0] retired;
      logic [VCW-1:0]    vc;
      logic [DIW-1:0]    ei;
      logic [RAW-1:0]    lbase;
      logic              ovf;
      logic              rsp_valid;
      logic [IdW-1:0]    rsp_first;
      logic [IdW-1:0]    rsp_second;
      logic [IdW-1:0]    rsp_new;
      logic [LinkW-1:0]  rsp_link;
      logic              rsp_last;
      logic              rsp_ovf;
   } ctl_type;

   ctl_type ctl_ff, ctl_in;
   logic [NumGroupsW-1:0] num_groups_ff, num_groups_in;
   logic [DimW-1:0]       dim_in_use_ff, dim_in_use_in;

   logic              rank_we;
   logic [RAW-1:0]    rank_waddr, rank_raddr;
   logic [RankW-1:0]  rank_rdata;
   logic              vcl_we;
   logic [GroupW-1:0] vcl_rdata;
   logic              lab_we;
   logic [IdW-1:0]    lab_wdata, lab_rdata;
   logic              ma_we, mb_we;
   logic [VIW-1:0]    ma_rdata, mb_rdata;
   logic              lk_we;
   logic [LinkW-1:0]  lk_rdata;

   logic [31:0]       dim_ext;
   logic [CW-1:0]     prod;
   logic [RankW-1:0]  diff;
   logic [LinkW:0]    sum;
   logic [LinkW-1:0]  new_m;

   // configuration registers
   always_comb begin
      num_groups_in = num_groups_ff;
      dim_in_use_in = dim_in_use_ff;
      if (csr_write) begin
         unique case (csr_index)
            CsrNumGroups: num_groups_in = csr_data[NumGroupsW-1:0];
            CsrDimInUse:  dim_in_use_in = csr_data[DimW-1:0];
            default:      num_groups_in = num_groups_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_groups_ff <= NumGroupsReset;
         dim_in_use_ff <= DimReset;
      end else begin
         num_groups_ff <= num_groups_in;
         dim_in_use_ff <= dim_in_use_in;
      end
   end

   assign dim_ext = 32'(dim_in_use_ff);
   assign prod    = CW'(ctl_ff.na) * CW'(ctl_ff.nb);
   assign diff    = (ctl_ff.ra > rank_rdata) ? (ctl_ff.ra - rank_rdata)
                                             : (rank_rdata - ctl_ff.ra);
   assign sum     = {1'b0, ctl_ff.acc} + (LinkW+1)'(diff);
   assign new_m   = (ctl_ff.cnt <= ctl_ff.k) ? ctl_ff.t : ctl_ff.m;

   // sequencer
   always_comb begin
      ctl_in     = ctl_ff;
      rank_we    = 1'b0;
      rank_waddr = ctl_ff.lbase + RAW'(ctl_ff.ei);
      rank_raddr = ctl_ff.base_a + RAW'(ctl_ff.e);
      vcl_we     = 1'b0;
      lab_we     = 1'b0;
      lab_wdata  = ctl_ff.next;
      ma_we      = 1'b0;
      mb_we      = 1'b0;
      lk_we      = 1'b0;
      unique case (ctl_ff.state)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KindLoad) begin
                  if (ctl_ff.vc < VCW'(MAX_VECTORS)) begin
                     rank_we = 1'b1;
                  end else begin
                     ctl_in.ovf = 1'b1;
                  end
                  if (req_vector_end) begin
                     if (ctl_ff.vc < VCW'(MAX_VECTORS)) begin
                        vcl_we       = 1'b1;
                        ctl_in.vc    = ctl_ff.vc + 1'b1;
                        ctl_in.lbase = ctl_ff.lbase + RAW'(MAX_DIM);
                     end
                     ctl_in.ei = '0;
                  end else if (32'(ctl_ff.ei) < 32'(MAX_DIM - 1)) begin
                     ctl_in.ei = ctl_ff.ei + 1'b1;
                  end
               end else begin
                  ctl_in.retired = '0;
                  if (num_groups_ff < 7'd2) begin
                     ctl_in.ng = 7'd2;
                  end else if (32'(num_groups_ff) > 32'(MAX_GROUPS)) begin
                     ctl_in.ng = IdW'(MAX_GROUPS);
                  end else begin
                     ctl_in.ng = num_groups_ff;
                  end
                  if (dim_ext == 32'd0) begin
                     ctl_in.dim_m1 = '0;
                  end else if (dim_ext > 32'(MAX_DIM)) begin
                     ctl_in.dim_m1 = DIW'(MAX_DIM - 1);
                  end else begin
                     ctl_in.dim_m1 = DIW'(dim_ext - 32'd1);
                  end
                  ctl_in.v     = '0;
                  ctl_in.state = S_CP_RD;
               end
            end
         end
         S_CP_RD: begin
            if (ctl_ff.v == ctl_ff.vc) begin
               ctl_in.li    = '0;
               ctl_in.lj    = 8'd1;
               ctl_in.phase = 1'b0;
               ctl_in.next  = ctl_ff.ng;
               ctl_in.ca    = '0;
               ctl_in.cb    = 7'd1;
               ctl_in.v     = '0;
               ctl_in.na    = '0;
               ctl_in.nb    = '0;
               ctl_in.state = S_LS_RD;
            end else begin
               ctl_in.state = S_CP_WR;
            end
         end
         S_CP_WR: begin
            lab_we       = 1'b1;
            lab_wdata    = ({1'b0, vcl_rdata} < ctl_ff.ng) ? {1'b0, vcl_rdata} : NoCluster;
            ctl_in.v     = ctl_ff.v + 1'b1;
            ctl_in.state = S_CP_RD;
         end
         S_LS_RD: begin
            ctl_in.state = (ctl_ff.v == ctl_ff.vc) ? S_LS_END : S_LS_CHK;
         end
         S_LS_CHK: begin
            if (lab_rdata == ctl_ff.ca) begin
               ma_we     = 1'b1;
               ctl_in.na = ctl_ff.na + 1'b1;
            end else if (lab_rdata == ctl_ff.cb) begin
               mb_we     = 1'b1;
               ctl_in.nb = ctl_ff.nb + 1'b1;
            end
            ctl_in.v     = ctl_ff.v + 1'b1;
            ctl_in.state = S_LS_RD;
         end
         S_LS_END: begin
            if (ctl_ff.na == '0 || ctl_ff.nb == '0) begin
               ctl_in.lres  = LinkSat;
               ctl_in.state = S_LK_DONE;
            end else begin
               ctl_in.k      = prod >> 1;
               ctl_in.bitpos = 4'd15;
               ctl_in.m      = '0;
               ctl_in.t      = 16'h8000;
               ctl_in.cnt    = '0;
               ctl_in.pi     = '0;
               ctl_in.pj     = '0;
               ctl_in.state  = S_P_ADDR;
            end
         end
         S_P_ADDR: begin
            ctl_in.state = S_P_BASE;
         end
         S_P_BASE: begin
            ctl_in.base_a = RAW'(ma_rdata) * RAW'(MAX_DIM);
            ctl_in.base_b = RAW'(mb_rdata) * RAW'(MAX_DIM);
            ctl_in.e      = '0;
            ctl_in.acc    = '0;
            ctl_in.state  = S_E_RDA;
         end
         S_E_RDA: begin
            ctl_in.state = S_E_RDB;
         end
         S_E_RDB: begin
            rank_raddr   = ctl_ff.base_b + RAW'(ctl_ff.e);
            ctl_in.ra    = rank_rdata;
            ctl_in.state = S_E_ACC;
         end
         S_E_ACC: begin
            ctl_in.acc = sum[LinkW] ? LinkSat : sum[LinkW-1:0];
            if (ctl_ff.e == ctl_ff.dim_m1) begin
               ctl_in.state = S_P_CMP;
            end else begin
               ctl_in.e     = ctl_ff.e + 1'b1;
               ctl_in.state = S_E_RDA;
            end
         end
         S_P_CMP: begin
            if (ctl_ff.acc < ctl_ff.t) begin
               ctl_in.cnt = ctl_ff.cnt + 1'b1;
            end
            if (ctl_ff.pj == ctl_ff.nb - 1'b1) begin
               ctl_in.pj = '0;
               if (ctl_ff.pi == ctl_ff.na - 1'b1) begin
                  ctl_in.state = S_B_END;
               end else begin
                  ctl_in.pi    = ctl_ff.pi + 1'b1;
                  ctl_in.state = S_P_ADDR;
               end
            end else begin
               ctl_in.pj    = ctl_ff.pj + 1'b1;
               ctl_in.state = S_P_ADDR;
            end
         end
         S_B_END: begin
            ctl_in.m = new_m;
            if (ctl_ff.bitpos == 4'd0) begin
               ctl_in.lres  = new_m;
               ctl_in.state = S_LK_DONE;
            end else begin
               ctl_in.bitpos = ctl_ff.bitpos - 4'd1;
               ctl_in.t      = new_m | (16'h1 << (ctl_ff.bitpos - 4'd1));
               ctl_in.cnt    = '0;
               ctl_in.pi     = '0;
               ctl_in.pj     = '0;
               ctl_in.state  = S_P_ADDR;
            end
         end
         S_LK_DONE: begin
            lk_we = 1'b1;
            if (!ctl_ff.phase) begin
               if (ctl_ff.lj + 8'd1 < {1'b0, ctl_ff.ng}) begin
                  ctl_in.lj    = ctl_ff.lj + 8'd1;
                  ctl_in.ca    = ctl_ff.li[IdW-1:0];
                  ctl_in.cb    = IdW'(ctl_ff.lj + 8'd1);
                  ctl_in.v     = '0;
                  ctl_in.na    = '0;
                  ctl_in.nb    = '0;
                  ctl_in.state = S_LS_RD;
               end else if (ctl_ff.li + 8'd2 < {1'b0, ctl_ff.ng}) begin
                  ctl_in.li    = ctl_ff.li + 8'd1;
                  ctl_in.lj    = ctl_ff.li + 8'd2;
                  ctl_in.ca    = IdW'(ctl_ff.li + 8'd1);
                  ctl_in.cb    = IdW'(ctl_ff.li + 8'd2);
                  ctl_in.v     = '0;
                  ctl_in.na    = '0;
                  ctl_in.nb    = '0;
                  ctl_in.state = S_LS_RD;
               end else begin
                  ctl_in.si    = '0;
                  ctl_in.sj    = 8'd1;
                  ctl_in.found = 1'b0;
                  ctl_in.best  = LinkSat;
                  ctl_in.state = S_FB_NEXT;
               end
            end else begin
               ctl_in.li    = ctl_ff.li + 8'd1;
               ctl_in.state = S_NL_NEXT;
            end
         end
         S_FB_NEXT: begin
            if (ctl_ff.si >= {1'b0, ctl_ff.next}) begin
               ctl_in.rsp_valid  = 1'b1;
               ctl_in.rsp_first  = ctl_ff.c1;
               ctl_in.rsp_second = ctl_ff.c2;
               ctl_in.rsp_new    = ctl_ff.next;
               ctl_in.rsp_link   = ctl_ff.best;
               ctl_in.rsp_last   = ({1'b0, ctl_ff.next} + 8'd2) == {ctl_ff.ng, 1'b0};
               ctl_in.rsp_ovf    = ctl_ff.ovf;
               ctl_in.state      = S_EMIT;
            end else if (ctl_ff.sj >= {1'b0, ctl_ff.next}
                         || ctl_ff.retired[ctl_ff.si[IdW-1:0]]) begin
               ctl_in.si = ctl_ff.si + 8'd1;
               ctl_in.sj = ctl_ff.si + 8'd2;
            end else if (ctl_ff.retired[ctl_ff.sj[IdW-1:0]]) begin
               ctl_in.sj = ctl_ff.sj + 8'd1;
            end else begin
               ctl_in.state = S_FB_CMP;
            end
         end
         S_FB_CMP: begin
            if (!ctl_ff.found || lk_rdata < ctl_ff.best) begin
               ctl_in.found = 1'b1;
               ctl_in.c1    = ctl_ff.si[IdW-1:0];
               ctl_in.c2    = ctl_ff.sj[IdW-1:0];
               ctl_in.best  = lk_rdata;
            end
            ctl_in.sj    = ctl_ff.sj + 8'd1;
            ctl_in.state = S_FB_NEXT;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               ctl_in.rsp_valid           = 1'b0;
               ctl_in.retired[ctl_ff.c1]  = 1'b1;
               ctl_in.retired[ctl_ff.c2]  = 1'b1;
               ctl_in.v                   = '0;
               ctl_in.state               = ctl_ff.rsp_last ? S_IDLE : S_RL_RD;
            end
         end
         S_RL_RD: begin
            if (ctl_ff.v == ctl_ff.vc) begin
               ctl_in.li    = '0;
               ctl_in.state = S_NL_NEXT;
            end else begin
               ctl_in.state = S_RL_WR;
            end
         end
         S_RL_WR: begin
            if (lab_rdata == ctl_ff.c1 || lab_rdata == ctl_ff.c2) begin
               lab_we = 1'b1;
            end
            ctl_in.v     = ctl_ff.v + 1'b1;
            ctl_in.state = S_RL_RD;
         end
         S_NL_NEXT: begin
            if (ctl_ff.li == {1'b0, ctl_ff.next}) begin
               ctl_in.next  = ctl_ff.next + 1'b1;
               ctl_in.si    = '0;
               ctl_in.sj    = 8'd1;
               ctl_in.found = 1'b0;
               ctl_in.best  = LinkSat;
               ctl_in.state = S_FB_NEXT;
            end else if (ctl_ff.retired[ctl_ff.li[IdW-1:0]]) begin
               ctl_in.li = ctl_ff.li + 8'd1;
            end else begin
               ctl_in.ca    = ctl_ff.li[IdW-1:0];
               ctl_in.cb    = ctl_ff.next;
               ctl_in.phase = 1'b1;
               ctl_in.v     = '0;
               ctl_in.na    = '0;
               ctl_in.nb    = '0;
               ctl_in.state = S_LS_RD;
            end
         end
         default: ctl_in.state = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // stores
   mlcm_ram #(.WIDTH(RankW), .DEPTH(RankDepth)) u_rank_store (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (req_rank_value),
      .rd_addr (rank_raddr),
      .rd_data (rank_rdata)
   );

   mlcm_ram #(.WIDTH(GroupW), .DEPTH(MAX_VECTORS)) u_vector_cluster (
      .clock   (clock),
      .wr_en   (vcl_we),
      .wr_addr (ctl_ff.vc[VIW-1:0]),
      .wr_data (req_group),
      .rd_addr (ctl_ff.v[VIW-1:0]),
      .rd_data (vcl_rdata)
   );

   mlcm_ram #(.WIDTH(IdW), .DEPTH(MAX_VECTORS)) u_label (
      .clock   (clock),
      .wr_en   (lab_we),
      .wr_addr (ctl_ff.v[VIW-1:0]),
      .wr_data (lab_wdata),
      .rd_addr (ctl_ff.v[VIW-1:0]),
      .rd_data (lab_rdata)
   );

   mlcm_ram #(.WIDTH(VIW), .DEPTH(MAX_VECTORS)) u_members_a (
      .clock   (clock),
      .wr_en   (ma_we),
      .wr_addr (ctl_ff.na[VIW-1:0]),
      .wr_data (ctl_ff.v[VIW-1:0]),
      .rd_addr (ctl_ff.pi[VIW-1:0]),
      .rd_data (ma_rdata)
   );

   mlcm_ram #(.WIDTH(VIW), .DEPTH(MAX_VECTORS)) u_members_b (
      .clock   (clock),
      .wr_en   (mb_we),
      .wr_addr (ctl_ff.nb[VIW-1:0]),
      .wr_data (ctl_ff.v[VIW-1:0]),
      .rd_addr (ctl_ff.pj[VIW-1:0]),
      .rd_data (mb_rdata)
   );

   mlcm_ram #(.WIDTH(LinkW), .DEPTH(LinkDepth)) u_link_tab (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr ({ctl_ff.ca, ctl_ff.cb}),
      .wr_data (ctl_ff.lres),
      .rd_addr ({ctl_ff.si[IdW-1:0], ctl_ff.sj[IdW-1:0]}),
      .rd_data (lk_rdata)
   );

   assign req_stall          = (ctl_ff.state != S_IDLE);
   assign rsp_valid          = ctl_ff.rsp_valid;
   assign rsp_child_first    = ctl_ff.rsp_first;
   assign rsp_child_second   = ctl_ff.rsp_second;
   assign rsp_new_cluster    = ctl_ff.rsp_new;
   assign rsp_linkage        = ctl_ff.rsp_link;
   assign rsp_last           = ctl_ff.rsp_last;
   assign rsp_store_overflow = ctl_ff.rsp_ovf;

   // checks
   `MLCM_ASSERT(a_rsp_only_in_emit, clock, reset, ctl_ff.rsp_valid |-> (ctl_ff.state == S_EMIT))
   `MLCM_ASSERT(a_children_ordered, clock, reset, ctl_ff.rsp_valid |-> (ctl_ff.rsp_first < ctl_ff.rsp_second))
   `MLCM_ASSERT(a_pair_live, clock, reset, (ctl_ff.state == S_FB_CMP) |-> (!ctl_ff.retired[ctl_ff.si[IdW-1:0]] && !ctl_ff.retired[ctl_ff.sj[IdW-1:0]] && (ctl_ff.si < ctl_ff.sj)))
   `MLCM_ASSERT(a_children_retired, clock, reset, ((ctl_ff.state == S_EMIT) && !rsp_stall) |=> (ctl_ff.retired[ctl_ff.c1] && ctl_ff.retired[ctl_ff.c2]))
   `MLCM_ASSERT_NEVER(a_emit_without_pair, clock, reset, ctl_ff.rsp_valid && !ctl_ff.found)
endmodule

/* design/mlcm_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module mlcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
